@@ sv/nnsb_pkg.sv @@
// Shared types, field widths and codes for the scaled blit address generator.
package nnsb_pkg;

	localparam int SCREEN_BITS_DEF = 13;
	localparam int IMAGE_BITS_DEF  = 14;
	localparam int ORIGIN_BITS     = 16;
	localparam int SCALED_BITS     = 16;
	localparam int DEST_BITS       = 14;
	localparam int ARITH_BITS      = 18;
	localparam int CFG_ADDR_BITS   = 2;

	localparam logic [CFG_ADDR_BITS-1:0] CFG_SRC_W   = 2'd0;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_SRC_H   = 2'd1;
	localparam logic [CFG_ADDR_BITS-1:0] CFG_PRESENT = 2'd2;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = 1;

	typedef struct packed {
		logic                   pixel;
		logic                   last;
		logic [ORIGIN_BITS-1:0] dx;
		logic [ORIGIN_BITS-1:0] dy;
		logic [SCALED_BITS-1:0] scaled_w;
		logic [SCALED_BITS-1:0] scaled_h;
		logic [DEST_BITS-1:0]   dest_x;
		logic [DEST_BITS-1:0]   dest_y;
	} q_entry_t;

	typedef enum logic [4:0] {
		B_IDLE = 5'b00001,
		B_MUL  = 5'b00010,
		B_DIV  = 5'b00100,
		B_IDX  = 5'b01000,
		B_DONE = 5'b10000
	} back_state_t;

endpackage

@@ sv/nnsb_front.sv @@
// Front end: accepts items, clips the blit rectangle and walks the raster cursor.
module nnsb_front import nnsb_pkg::*; #(
	parameter int SCREEN_BITS = SCREEN_BITS_DEF,
	localparam int IN_RAW = 2*ORIGIN_BITS + 4*SCREEN_BITS + 2*SCALED_BITS,
	localparam int IN_W = ((IN_RAW + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            in_op,
	input  logic [IN_W-1:0] in_data,
	input  logic            present,
	input  logic            q_full,
	output logic            q_push,
	output q_entry_t        q_entry
);

	localparam int CW    = SCREEN_BITS + 1;
	localparam int OX_LO = 0;
	localparam int OY_LO = ORIGIN_BITS;
	localparam int VX_LO = 2*ORIGIN_BITS;
	localparam int VY_LO = VX_LO + SCREEN_BITS;
	localparam int VW_LO = VY_LO + SCREEN_BITS;
	localparam int VH_LO = VW_LO + SCREEN_BITS;
	localparam int SW_LO = VH_LO + SCREEN_BITS;
	localparam int SH_LO = SW_LO + SCALED_BITS;

	logic signed [ORIGIN_BITS-1:0] ox_raw, oy_raw;
	logic [SCREEN_BITS-1:0] vx_raw, vy_raw, vw_raw, vh_raw;
	logic [SCALED_BITS-1:0] sw_raw, sh_raw;
	logic signed [ARITH_BITS-1:0] ox, oy, vx, vy, vr, vb, xe, ye, x1, y1, x2, y2;
	logic signed [ARITH_BITS-1:0] dxf, dyf;
	logic draw, accept, x_end, y_end, last;

	logic          active_q;
	logic [CW-1:0] cur_x_q, cur_y_q, clip_l_q, clip_r_q, clip_b_q;
	logic signed [ORIGIN_BITS-1:0] org_x_q, org_y_q;
	logic [SCALED_BITS-1:0] scl_w_q, scl_h_q;

	assign ox_raw = in_data[OX_LO +: ORIGIN_BITS];
	assign oy_raw = in_data[OY_LO +: ORIGIN_BITS];
	assign vx_raw = in_data[VX_LO +: SCREEN_BITS];
	assign vy_raw = in_data[VY_LO +: SCREEN_BITS];
	assign vw_raw = in_data[VW_LO +: SCREEN_BITS];
	assign vh_raw = in_data[VH_LO +: SCREEN_BITS];
	assign sw_raw = in_data[SW_LO +: SCALED_BITS];
	assign sh_raw = in_data[SH_LO +: SCALED_BITS];

	always_comb begin
		ox = ARITH_BITS'(ox_raw);
		oy = ARITH_BITS'(oy_raw);
		vx = signed'(ARITH_BITS'(vx_raw));
		vy = signed'(ARITH_BITS'(vy_raw));
		vr = vx + signed'(ARITH_BITS'(vw_raw));
		vb = vy + signed'(ARITH_BITS'(vh_raw));
		xe = ox + signed'(ARITH_BITS'(sw_raw));
		ye = oy + signed'(ARITH_BITS'(sh_raw));
		x1 = (ox < vx) ? vx : ox;
		y1 = (oy < vy) ? vy : oy;
		x2 = (xe > vr) ? vr : xe;
		y2 = (ye > vb) ? vb : ye;
		draw = present && (sw_raw != '0) && (sh_raw != '0) && (vw_raw != '0) &&
			(vh_raw != '0) && (x1 < x2) && (y1 < y2);
	end

	always_comb begin
		dxf = signed'(ARITH_BITS'(cur_x_q)) - ARITH_BITS'(org_x_q);
		dyf = signed'(ARITH_BITS'(cur_y_q)) - ARITH_BITS'(org_y_q);
		x_end = ({1'b0, cur_x_q} + (CW+1)'(1)) >= {1'b0, clip_r_q};
		y_end = ({1'b0, cur_y_q} + (CW+1)'(1)) >= {1'b0, clip_b_q};
		last = x_end && y_end;
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept;

	always_comb begin
		q_entry = '0;
		if (in_op == OP_STEP && active_q) begin
			q_entry.pixel    = 1'b1;
			q_entry.last     = last;
			q_entry.dx       = dxf[ORIGIN_BITS-1:0];
			q_entry.dy       = dyf[ORIGIN_BITS-1:0];
			q_entry.scaled_w = scl_w_q;
			q_entry.scaled_h = scl_h_q;
			q_entry.dest_x   = DEST_BITS'(cur_x_q);
			q_entry.dest_y   = DEST_BITS'(cur_y_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			clip_l_q <= '0;
			clip_r_q <= '0;
			clip_b_q <= '0;
			org_x_q  <= '0;
			org_y_q  <= '0;
			scl_w_q  <= '0;
			scl_h_q  <= '0;
		end else if (accept) begin
			if (in_op == OP_START) begin
				active_q <= draw;
				if (draw) begin
					clip_l_q <= x1[CW-1:0];
					clip_r_q <= x2[CW-1:0];
					clip_b_q <= y2[CW-1:0];
					cur_x_q  <= x1[CW-1:0];
					cur_y_q  <= y1[CW-1:0];
					org_x_q  <= ox_raw;
					org_y_q  <= oy_raw;
					scl_w_q  <= sw_raw;
					scl_h_q  <= sh_raw;
				end
			end else if (active_q) begin
				if (last) begin
					active_q <= 1'b0;
				end else if (x_end) begin
					cur_x_q <= clip_l_q;
					cur_y_q <= cur_y_q + CW'(1);
				end else begin
					cur_x_q <= cur_x_q + CW'(1);
				end
			end
		end
	end

endmodule

@@ sv/nnsb_queue.sv @@
// Two-entry queue that decouples the front end from the address back end.
module nnsb_queue import nnsb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t din,
	output logic     full,
	output logic     valid,
	input  logic     pop,
	output q_entry_t dout
);

	q_entry_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QPTR_BITS:0]     count_q;

	assign full  = count_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign valid = count_q != '0;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_BITS+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_BITS+1)'(1);
			end
		end
	end

endmodule

@@ sv/nnsb_back.sv @@
// Back end: scales offsets to source coordinates, forms the index, holds the result.
module nnsb_back import nnsb_pkg::*; #(
	parameter int IMAGE_BITS = IMAGE_BITS_DEF,
	localparam int OUT_RAW = 2*DEST_BITS + 4*IMAGE_BITS,
	localparam int OUT_W = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  q_entry_t              q_entry,
	input  logic [IMAGE_BITS-1:0] src_w,
	input  logic [IMAGE_BITS-1:0] src_h,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  out_pixel,
	output logic                  out_last,
	output logic [OUT_W-1:0]      out_data
);

	localparam int PW        = ORIGIN_BITS + IMAGE_BITS;
	localparam int IW        = 2*IMAGE_BITS;
	localparam int CNT_BITS  = $clog2(IMAGE_BITS + 1);

	back_state_t             st_q;
	q_entry_t                ent_q;
	logic [SCALED_BITS-1:0]  rem_x_q, rem_y_q;
	logic [IMAGE_BITS-1:0]   quo_x_q, quo_y_q;
	logic [CNT_BITS-1:0]     cnt_q;

	logic                    res_pixel_q, res_last_q;
	logic [DEST_BITS-1:0]    res_dx_q, res_dy_q;
	logic [IMAGE_BITS-1:0]   res_sx_q, res_sy_q;
	logic [IW-1:0]           res_idx_q;

	logic                    out_valid_q, out_pixel_q, out_last_q;
	logic [OUT_W-1:0]        out_data_q;

	logic [PW-1:0]           prod_x, prod_y;
	logic [SCALED_BITS:0]    sh_x, sh_y, df_x, df_y;
	logic                    qb_x, qb_y;
	logic [SCALED_BITS-1:0]  rem_x_n, rem_y_n;
	logic [IMAGE_BITS-1:0]   sx, sy;
	logic [IW-1:0]           idx;
	logic                    load_out;

	assign q_pop    = (st_q == B_IDLE) && q_valid;
	assign load_out = (st_q == B_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		prod_x = PW'(ent_q.dx) * PW'(src_w);
		prod_y = PW'(ent_q.dy) * PW'(src_h);
	end

	always_comb begin
		sh_x    = {rem_x_q, quo_x_q[IMAGE_BITS-1]};
		sh_y    = {rem_y_q, quo_y_q[IMAGE_BITS-1]};
		df_x    = sh_x - {1'b0, ent_q.scaled_w};
		df_y    = sh_y - {1'b0, ent_q.scaled_h};
		qb_x    = sh_x >= {1'b0, ent_q.scaled_w};
		qb_y    = sh_y >= {1'b0, ent_q.scaled_h};
		rem_x_n = qb_x ? df_x[SCALED_BITS-1:0] : sh_x[SCALED_BITS-1:0];
		rem_y_n = qb_y ? df_y[SCALED_BITS-1:0] : sh_y[SCALED_BITS-1:0];
	end

	always_comb begin
		sx  = ((src_w != '0) && (quo_x_q >= src_w)) ? src_w - IMAGE_BITS'(1) : quo_x_q;
		sy  = ((src_h != '0) && (quo_y_q >= src_h)) ? src_h - IMAGE_BITS'(1) : quo_y_q;
		idx = IW'(sy) * IW'(src_w) + IW'(sx);
	end

	always_ff @(posedge clk) begin
		case (st_q)
			B_IDLE: begin
				ent_q <= q_entry;
				if (!q_entry.pixel) begin
					res_pixel_q <= 1'b0;
					res_last_q  <= 1'b0;
					res_dx_q    <= '0;
					res_dy_q    <= '0;
					res_sx_q    <= '0;
					res_sy_q    <= '0;
					res_idx_q   <= '0;
				end
			end
			B_MUL: begin
				rem_x_q <= prod_x[PW-1:IMAGE_BITS];
				quo_x_q <= prod_x[IMAGE_BITS-1:0];
				rem_y_q <= prod_y[PW-1:IMAGE_BITS];
				quo_y_q <= prod_y[IMAGE_BITS-1:0];
			end
			B_DIV: begin
				rem_x_q <= rem_x_n;
				rem_y_q <= rem_y_n;
				quo_x_q <= {quo_x_q[IMAGE_BITS-2:0], qb_x};
				quo_y_q <= {quo_y_q[IMAGE_BITS-2:0], qb_y};
			end
			B_IDX: begin
				res_pixel_q <= 1'b1;
				res_last_q  <= ent_q.last;
				res_dx_q    <= ent_q.dest_x;
				res_dy_q    <= ent_q.dest_y;
				res_sx_q    <= sx;
				res_sy_q    <= sy;
				res_idx_q   <= idx;
			end
			default: begin
			end
		endcase
		if (load_out) begin
			out_pixel_q <= res_pixel_q;
			out_last_q  <= res_last_q;
			out_data_q  <= OUT_W'({res_idx_q, res_sy_q, res_sx_q, res_dy_q, res_dx_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				B_IDLE: begin
					if (q_valid) begin
						st_q <= q_entry.pixel ? B_MUL : B_DONE;
					end
				end
				B_MUL: begin
					cnt_q <= '0;
					st_q  <= B_DIV;
				end
				B_DIV: begin
					cnt_q <= cnt_q + CNT_BITS'(1);
					if (cnt_q == CNT_BITS'(IMAGE_BITS - 1)) begin
						st_q <= B_IDX;
					end
				end
				B_IDX: begin
					st_q <= B_DONE;
				end
				B_DONE: begin
					if (load_out) begin
						st_q <= B_IDLE;
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign out_last  = out_last_q;
	assign out_data  = out_data_q;

endmodule

@@ sv/nearest_neighbor_scaled_blit_addresses_core.sv @@
// Top level of the nearest-neighbor scaled blit address generator.
// A start item (tuser 0) clips the scaled image rectangle against the viewport and
// answers with one all-zero result; each step item (tuser 1) returns the next
// destination pixel in raster order with its source column, row and pixel index,
// tlast on the final pixel, or an all-zero result with tuser 0 when no blit runs.
// The front end takes one item per cycle into a two-entry queue while it is not full.
// In the back end a step result passes the multiply, divide, index and done states,
// the restoring divider retiring one quotient bit per cycle for column and row;
// a start or idle step result goes from idle straight to done. Source sizes and the
// image-present flag are written through the cfg port, index 0 width, 1 height,
// 2 present; write them only while no item is in flight.
module nearest_neighbor_scaled_blit_addresses_core import nnsb_pkg::*; #(
	parameter int SCREEN_BITS = SCREEN_BITS_DEF,
	parameter int IMAGE_BITS  = IMAGE_BITS_DEF,
	localparam int IN_RAW  = 2*ORIGIN_BITS + 4*SCREEN_BITS + 2*SCALED_BITS,
	localparam int IN_W    = ((IN_RAW + 7) / 8) * 8,
	localparam int OUT_RAW = 2*DEST_BITS + 4*IMAGE_BITS,
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// origin_x, origin_y, view_x, view_y, view_width, view_height, scaled_width,
	// scaled_height
	input  logic [IN_W-1:0]          s_tdata,
	// opcode
	input  logic                     s_tuser,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// dest_x, dest_y, source_x, source_y, source_index
	output logic [OUT_W-1:0]         m_tdata,
	// pixel_valid
	output logic                     m_tuser,
	output logic                     m_tlast,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [IMAGE_BITS-1:0]    cfg_data
);

	logic [IMAGE_BITS-1:0] src_w_q, src_h_q;
	logic                  present_q;
	logic                  q_push, q_full, q_valid, q_pop;
	q_entry_t              q_din, q_dout;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q   <= '0;
			src_h_q   <= '0;
			present_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				CFG_SRC_W:   src_w_q   <= cfg_data;
				CFG_SRC_H:   src_h_q   <= cfg_data;
				CFG_PRESENT: present_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	nnsb_front #(
		.SCREEN_BITS(SCREEN_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tuser),
		.in_data  (s_tdata),
		.present  (present_q),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_din)
	);

	nnsb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.valid  (q_valid),
		.pop    (q_pop),
		.dout   (q_dout)
	);

	nnsb_back #(
		.IMAGE_BITS(IMAGE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_entry   (q_dout),
		.src_w     (src_w_q),
		.src_h     (src_h_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pixel (m_tuser),
		.out_last  (m_tlast),
		.out_data  (m_tdata)
	);

endmodule

@@ sv/nnsb_checker.sv @@
// Port-level checker for the scaled blit address generator, bound to the top level.
module nnsb_checker import nnsb_pkg::*; #(
	parameter int IMAGE_BITS  = IMAGE_BITS_DEF,
	localparam int OUT_RAW = 2*DEST_BITS + 4*IMAGE_BITS,
	localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic                     s_tuser,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [OUT_W-1:0]         m_tdata,
	input logic                     m_tuser,
	input logic                     m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
			$stable(m_tlast))
		else $error("result changed while stalled");

	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata == '0) && !m_tlast)
		else $error("non-pixel result carries data");

	a_last_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("last marker on a non-pixel result");

	a_step_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_START && m_tvalid && m_tready && m_tlast
			|=> !(m_tvalid && m_tlast))
		else $error("second last marker right after start and last");

endmodule

bind nearest_neighbor_scaled_blit_addresses_core nnsb_checker #(
	.IMAGE_BITS(IMAGE_BITS)
) u_nnsb_checker (.*);
